@@ rtl/cascaded_balance_pid_drive_defines.svh @@
// assertion macros shared by the balance drive rtl
// no dependencies; included by files that carry assertions
`ifndef CASCADED_BALANCE_PID_DRIVE_DEFINES_SVH
`define CASCADED_BALANCE_PID_DRIVE_DEFINES_SVH

// same-cycle implication
`define CBPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cbpd_pkg.sv @@
// types, constants and helper functions for the balance drive controller
// no dependencies; used by every rtl module of the block
`default_nettype none

package cbpd_pkg;

   localparam int DUTY_PERIOD = 500;
   localparam int SPEED_DIV   = 25;
   localparam int TICKS_PER_S = 500;
   localparam int SPEED_SCALE = TICKS_PER_S / SPEED_DIV;
   localparam int TILT_OFFSET = -32;
   localparam int TILT_LIMIT  = 640;
   localparam int CLIP_MARGIN = 5;
   localparam int GAIN_SHIFT  = 8;

   // floor(x / 128000) = floor(floor(x / 1024) / 125), the last via reciprocal
   localparam int INT_SHIFT   = 10;
   localparam int DIV_SHIFT   = 30;
   localparam int DIV_M       = 8589935;
   localparam int DIV_BIAS_Q  = 16778;
   localparam int DIV_BIAS    = DIV_BIAS_Q * 125;
   localparam int DIV_Q_W     = 16;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int ACC_W       = 52;
   localparam int MUL_A_W     = 34;
   localparam int MUL_B_W     = 25;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int CLIP_W      = 18;

   typedef enum logic [2:0] {
      REG_TILT_KP  = 3'd0,
      REG_TILT_KI  = 3'd1,
      REG_TILT_KD  = 3'd2,
      REG_SPEED_KP = 3'd3,
      REG_SPEED_KI = 3'd4,
      REG_SPEED_KD = 3'd5,
      REG_TURN_KP  = 3'd6,
      REG_TURN_KD  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] tilt_angle;
      logic signed [15:0] pitch_rate;
      logic signed [31:0] right_count;
      logic signed [31:0] left_count;
      logic signed [15:0] speed_target;
      logic signed [15:0] turn_target;
   } req_type;

   typedef struct packed {
      logic [8:0] tilt_drive;
      logic [8:0] sum_drive;
      logic       tilt_dir;
      logic       sum_dir;
      logic       drive_enabled;
   } rsp_type;

   // gains as the datapath wants them, some already scaled by a constant
   typedef struct packed {
      logic signed [15:0] tilt_kp;
      logic signed [15:0] tilt_ki;
      logic signed [15:0] tilt_kd;
      logic signed [15:0] speed_kp;
      logic signed [20:0] speed_ki_div;
      logic signed [20:0] speed_kd_scaled;
      logic signed [15:0] turn_kp;
      logic signed [24:0] turn_kd_tick;
   } gains_type;

   function automatic logic signed [31:0] sat32(input logic signed [59:0] x);
      logic signed [59:0] hi;
      logic signed [59:0] lo;
      hi = 60'sh7FFFFFFF;
      lo = -60'sh80000000;
      if (x > hi) begin
         return 32'sh7FFFFFFF;
      end else if (x < lo) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [CLIP_W-1:0] clip_drive(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] lim;
      logic signed [CLIP_W-1:0] top;
      lim = ACC_W'(DUTY_PERIOD);
      top = CLIP_W'(DUTY_PERIOD - CLIP_MARGIN);
      if (x >= lim) begin
         return top;
      end else if (x <= -lim) begin
         return -top;
      end
      return x[CLIP_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/cascaded_balance_pid_drive.sv @@
// Balancing drive controller: one beat in gives one beat out. Each beat is
// worked through by a sequencer around a single registered 34x25 multiplier
// and one accumulator. The step sequence, set by the multiplier issue/consume
// order, is longer on the beats where the outer speed loop runs (every
// SPEED_DIV-th beat). A new beat is taken only once the sequencer is back in
// idle; req_stall is high while a beat is in work. A result waits in an
// output register and a new beat may be taken while it waits. Configuration
// must be written over the apb-style port only while idle; the block itself
// does not enforce it. Depends on cbpd_pkg, cbpd_csr, cbpd_mul and the shared
// assertion macros.
`default_nettype none

`include "cascaded_balance_pid_drive_defines.svh"

module cascaded_balance_pid_drive (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire cbpd_pkg::req_type                 req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output cbpd_pkg::rsp_type                      rsp_payload,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cbpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cbpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cbpd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import cbpd_pkg::*;

   typedef enum logic [20:0] {
      ST_IDLE      = 21'h000001,
      ST_AVG       = 21'h000002,
      ST_SPD_SCALE = 21'h000004,
      ST_SPD_ERR   = 21'h000008,
      ST_SPD_P     = 21'h000010,
      ST_SPD_D     = 21'h000020,
      ST_SPD_I     = 21'h000040,
      ST_SPD_INT   = 21'h000080,
      ST_SPD_DIV   = 21'h000100,
      ST_SPD_OUT   = 21'h000200,
      ST_TILT_ERR  = 21'h000400,
      ST_TILT_I    = 21'h000800,
      ST_TILT_P    = 21'h001000,
      ST_TILT_D    = 21'h002000,
      ST_TILT_DIV  = 21'h004000,
      ST_TILT_OUT  = 21'h008000,
      ST_TURN_ERR  = 21'h010000,
      ST_TURN_P    = 21'h020000,
      ST_TURN_D    = 21'h040000,
      ST_TURN_SUM  = 21'h080000,
      ST_FINISH    = 21'h100000
   } state_type;

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic                     speed_upd_ff, speed_upd_in;
   logic [4:0]               tick_ff, tick_in;
   logic signed [31:0]       avg_ff, avg_in;
   logic signed [31:0]       wsc_ff, wsc_in;
   logic signed [31:0]       pse_ff, pse_in;
   logic signed [31:0]       si_ff, si_in;
   logic signed [31:0]       held_ff, held_in;
   logic signed [31:0]       ti_ff, ti_in;
   logic signed [31:0]       pte_ff, pte_in;
   logic signed [31:0]       e_ff, e_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  o1_ff, o1_in;
   logic [1:0]               dirs_ff, dirs_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   gains_type                gains;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic                     req_take;
   logic [4:0]               tick_next;
   logic signed [32:0]       count_sum;
   logic signed [32:0]       delta;
   logic signed [31:0]       speed_w;
   logic signed [31:0]       se_w;
   logic signed [32:0]       dse;
   logic signed [32:0]       dte;
   logic signed [ACC_W-1:0]  prod_t;
   logic signed [16:0]       quot;
   logic signed [31:0]       tilt_e;
   logic signed [31:0]       turn_e;
   logic signed [CLIP_W-1:0] o0c;
   logic signed [CLIP_W-1:0] o1c;
   logic [CLIP_W-1:0]        o0_mag;
   logic [CLIP_W-1:0]        o1_mag;
   logic                     en;
   logic                     rsp_free;

   cbpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   cbpd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign tick_next = tick_ff + 5'd1;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   assign count_sum = 33'(req_ff.right_count) + 33'(req_ff.left_count);
   assign delta     = 33'(avg_ff) - 33'(wsc_ff);
   assign speed_w   = sat32(60'(prod));
   assign se_w      = sat32(60'(req_ff.speed_target) - 60'(speed_w));
   assign dse       = 33'(e_ff) - 33'(pse_ff);
   assign dte       = 33'(e_ff) - 33'(pte_ff);
   assign prod_t    = ACC_W'(prod >>> GAIN_SHIFT);
   assign quot      = signed'({1'b0, prod[DIV_SHIFT +: DIV_Q_W]}) - 17'(DIV_BIAS_Q);
   assign tilt_e    = sat32(60'(req_ff.tilt_angle) - 60'(held_ff) - 60'(TILT_OFFSET));
   assign turn_e    = sat32(60'(req_ff.turn_target)
                            - (60'(req_ff.right_count) - 60'(req_ff.left_count)));

   assign o0c    = clip_drive(acc_ff);
   assign o1c    = clip_drive(o1_ff);
   assign o0_mag = o0c[CLIP_W-1] ? CLIP_W'(-o0c) : CLIP_W'(o0c);
   assign o1_mag = o1c[CLIP_W-1] ? CLIP_W'(-o1c) : CLIP_W'(o1c);
   assign en     = (req_ff.tilt_angle <= 16'(TILT_LIMIT))
                 && (req_ff.tilt_angle >= -16'(TILT_LIMIT));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      speed_upd_in = speed_upd_ff;
      tick_in      = tick_ff;
      avg_in       = avg_ff;
      wsc_in       = wsc_ff;
      pse_in       = pse_ff;
      si_in        = si_ff;
      held_in      = held_ff;
      ti_in        = ti_ff;
      pte_in       = pte_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      o1_in        = o1_ff;
      dirs_in      = dirs_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in       = req_payload;
               tick_in      = tick_next;
               speed_upd_in = (tick_next >= 5'(SPEED_DIV));
               state_in     = ST_AVG;
            end
         end
         ST_AVG: begin
            avg_in   = 32'(count_sum >>> 1);
            state_in = speed_upd_ff ? ST_SPD_SCALE : ST_TILT_ERR;
         end
         // speed over the window in pulses per second
         ST_SPD_SCALE: begin
            mul_a    = MUL_A_W'(delta);
            mul_b    = MUL_B_W'(SPEED_SCALE);
            state_in = ST_SPD_ERR;
         end
         ST_SPD_ERR: begin
            e_in     = se_w;
            state_in = ST_SPD_P;
         end
         ST_SPD_P: begin
            mul_a    = MUL_A_W'(e_ff);
            mul_b    = MUL_B_W'(gains.speed_kp);
            state_in = ST_SPD_D;
         end
         ST_SPD_D: begin
            acc_in   = prod_t;
            mul_a    = MUL_A_W'(dse);
            mul_b    = MUL_B_W'(gains.speed_kd_scaled);
            state_in = ST_SPD_I;
         end
         ST_SPD_I: begin
            acc_in   = acc_ff + prod_t;
            mul_a    = MUL_A_W'(e_ff);
            mul_b    = MUL_B_W'(gains.speed_ki_div);
            state_in = ST_SPD_INT;
         end
         ST_SPD_INT: begin
            si_in    = sat32(60'(si_ff) + 60'(prod));
            state_in = ST_SPD_DIV;
         end
         ST_SPD_DIV: begin
            mul_a    = MUL_A_W'(si_ff >>> INT_SHIFT) + MUL_A_W'(DIV_BIAS);
            mul_b    = MUL_B_W'(DIV_M);
            state_in = ST_SPD_OUT;
         end
         ST_SPD_OUT: begin
            held_in  = sat32(60'(acc_ff) + 60'(quot));
            pse_in   = e_ff;
            wsc_in   = avg_ff;
            tick_in  = '0;
            state_in = ST_TILT_ERR;
         end
         ST_TILT_ERR: begin
            e_in     = tilt_e;
            state_in = ST_TILT_I;
         end
         ST_TILT_I: begin
            mul_a    = MUL_A_W'(e_ff);
            mul_b    = MUL_B_W'(gains.tilt_ki);
            state_in = ST_TILT_P;
         end
         ST_TILT_P: begin
            ti_in    = sat32(60'(ti_ff) + 60'(prod));
            mul_a    = MUL_A_W'(e_ff);
            mul_b    = MUL_B_W'(gains.tilt_kp);
            state_in = ST_TILT_D;
         end
         ST_TILT_D: begin
            acc_in   = prod_t;
            mul_a    = MUL_A_W'(req_ff.pitch_rate);
            mul_b    = MUL_B_W'(gains.tilt_kd);
            state_in = ST_TILT_DIV;
         end
         ST_TILT_DIV: begin
            acc_in   = acc_ff + prod_t;
            mul_a    = MUL_A_W'(ti_ff >>> INT_SHIFT) + MUL_A_W'(DIV_BIAS);
            mul_b    = MUL_B_W'(DIV_M);
            state_in = ST_TILT_OUT;
         end
         ST_TILT_OUT: begin
            acc_in   = acc_ff + ACC_W'(quot);
            o1_in    = acc_ff + ACC_W'(quot);
            state_in = ST_TURN_ERR;
         end
         ST_TURN_ERR: begin
            e_in     = turn_e;
            state_in = ST_TURN_P;
         end
         ST_TURN_P: begin
            mul_a    = MUL_A_W'(e_ff);
            mul_b    = MUL_B_W'(gains.turn_kp);
            state_in = ST_TURN_D;
         end
         ST_TURN_D: begin
            acc_in   = acc_ff + prod_t;
            mul_a    = MUL_A_W'(dte);
            mul_b    = MUL_B_W'(gains.turn_kd_tick);
            state_in = ST_TURN_SUM;
         end
         ST_TURN_SUM: begin
            acc_in   = acc_ff + prod_t;
            pte_in   = e_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (en) begin
                  dirs_in            = {~o0c[CLIP_W-1], o1c[CLIP_W-1]};
                  rsp_in.tilt_drive  = o1_mag[8:0];
                  rsp_in.sum_drive   = o0_mag[8:0];
                  rsp_in.tilt_dir    = o1c[CLIP_W-1];
                  rsp_in.sum_dir     = ~o0c[CLIP_W-1];
               end else begin
                  rsp_in.tilt_drive  = '0;
                  rsp_in.sum_drive   = '0;
                  rsp_in.tilt_dir    = dirs_ff[0];
                  rsp_in.sum_dir     = dirs_ff[1];
               end
               rsp_in.drive_enabled = en;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         wsc_ff       <= '0;
         pse_ff       <= '0;
         si_ff        <= '0;
         held_ff      <= '0;
         ti_ff        <= '0;
         pte_ff       <= '0;
         dirs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         wsc_ff       <= wsc_in;
         pse_ff       <= pse_in;
         si_ff        <= si_in;
         held_ff      <= held_in;
         ti_ff        <= ti_in;
         pte_ff       <= pte_in;
         dirs_ff      <= dirs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      speed_upd_ff <= speed_upd_in;
      avg_ff       <= avg_in;
      e_ff         <= e_in;
      acc_ff       <= acc_in;
      o1_ff        <= o1_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CBPD_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == ST_AVG, "beat taken but sequencer did not start")
   `CBPD_ASSERT_NOW(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall, "input not stalled while busy")
   `CBPD_ASSERT_NOW(a_off_zero, clock, reset, rsp_valid && !rsp_payload.drive_enabled, rsp_payload.tilt_drive == 9'd0 && rsp_payload.sum_drive == 9'd0, "drive non-zero while disabled")
   `CBPD_ASSERT_NOW(a_rsp_from_finish, clock, reset, $rose(rsp_valid), $past(state_ff == ST_FINISH), "result raised outside finish step")
   `CBPD_ASSERT_NOW(a_speed_only_on_window, clock, reset, state_ff == ST_SPD_SCALE, speed_upd_ff, "speed loop ran off its window")

endmodule

`default_nettype wire

@@ rtl/cbpd_csr.sv @@
// configuration registers of the balance drive, apb-style write and read
// depends on cbpd_pkg; pre-scales the gains that meet a constant factor
`default_nettype none

module cbpd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cbpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cbpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cbpd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready,
   output cbpd_pkg::gains_type                    gains
);
   import cbpd_pkg::*;

   logic [15:0]        regs_ff [8];
   logic [15:0]        regs_in [8];
   logic signed [20:0] ki_div_ff, ki_div_in;
   logic signed [20:0] kd_scaled_ff, kd_scaled_in;
   logic signed [24:0] turn_kd_ff, turn_kd_in;
   logic               wr_en;
   reg_index_type      idx;
   logic signed [20:0] wdata21;
   logic signed [24:0] wdata25;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wdata21    = 21'(signed'(csr_pwdata[15:0]));
   assign wdata25    = 25'(signed'(csr_pwdata[15:0]));

   always_comb begin
      regs_in      = regs_ff;
      ki_div_in    = ki_div_ff;
      kd_scaled_in = kd_scaled_ff;
      turn_kd_in   = turn_kd_ff;
      if (wr_en) begin
         regs_in[idx] = csr_pwdata[15:0];
         unique case (idx)
            REG_SPEED_KI: ki_div_in    = wdata21 * 21'(SPEED_DIV);
            REG_SPEED_KD: kd_scaled_in = wdata21 * 21'(SPEED_SCALE);
            REG_TURN_KD:  turn_kd_in   = wdata25 * 25'(TICKS_PER_S);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
         ki_div_ff    <= '0;
         kd_scaled_ff <= '0;
         turn_kd_ff   <= '0;
      end else begin
         regs_ff      <= regs_in;
         ki_div_ff    <= ki_div_in;
         kd_scaled_ff <= kd_scaled_in;
         turn_kd_ff   <= turn_kd_in;
      end
   end

   assign csr_prdata = {{16{regs_ff[idx][15]}}, regs_ff[idx]};

   assign gains.tilt_kp         = regs_ff[REG_TILT_KP];
   assign gains.tilt_ki         = regs_ff[REG_TILT_KI];
   assign gains.tilt_kd         = regs_ff[REG_TILT_KD];
   assign gains.speed_kp        = regs_ff[REG_SPEED_KP];
   assign gains.speed_ki_div    = ki_div_ff;
   assign gains.speed_kd_scaled = kd_scaled_ff;
   assign gains.turn_kp         = regs_ff[REG_TURN_KP];
   assign gains.turn_kd_tick    = turn_kd_ff;

endmodule

`default_nettype wire

@@ rtl/cbpd_mul.sv @@
// shared signed multiplier of the balance drive, product registered
// depends on cbpd_pkg for operand widths
`default_nettype none

module cbpd_mul (
   input  wire logic                                clock,
   input  wire logic signed [cbpd_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic signed [cbpd_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [cbpd_pkg::PROD_W-1:0]       prod
);
   import cbpd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking bench for cascaded_balance_pid_drive: queue-fed driver, clocked monitor,
// in-bench drive predictor, apb gain writes between phases; depends on cbpd_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
   import cbpd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cascaded_balance_pid_drive dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_type  pending_ticks[$];
   rsp_type  expected_drives[$];
   int       mismatch_count = 0;
   int       quiet_cycles = 0;
   bit       req_hs = 1'b0;
   bit       rsp_hs = 1'b0;
   bit       idle_on = 1'b1;
   bit       hold_ask = 1'b0;

   // predictor state
   longint   gain [8];
   int       tick_no = 0;
   longint   window_base = 0;
   longint   last_speed_err = 0;
   longint   speed_acc = 0;
   longint   tilt_setpoint_hold = 0;
   longint   tilt_acc = 0;
   longint   last_turn_err = 0;
   bit [1:0] held_dirs = 2'b00;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint duty_limit(longint x);
      if (x >= DUTY_PERIOD) return DUTY_PERIOD - CLIP_MARGIN;
      if (x <= -DUTY_PERIOD) return -(DUTY_PERIOD - CLIP_MARGIN);
      return x;
   endfunction

   function automatic rsp_type predict_drive(req_type r);
      longint  tilt, rate, rc, lc, avg, spd, se, p, d, e, tilt_out, sum_out, turn;
      rsp_type x;
      tilt = r.tilt_angle;
      rate = r.pitch_rate;
      rc   = r.right_count;
      lc   = r.left_count;
      avg  = floor_div(rc + lc, 2);
      tick_no = (tick_no + 1) % 32;
      if (tick_no >= SPEED_DIV) begin
         spd = clamp32(floor_div((avg - window_base) * TICKS_PER_S, SPEED_DIV));
         se  = clamp32(longint'(r.speed_target) - spd);
         p   = floor_div(gain[REG_SPEED_KP] * se, 256);
         d   = floor_div(gain[REG_SPEED_KD] * (se - last_speed_err) * TICKS_PER_S,
                         256 * SPEED_DIV);
         speed_acc = clamp32(speed_acc + gain[REG_SPEED_KI] * se * SPEED_DIV);
         tilt_setpoint_hold = clamp32(p + d + floor_div(speed_acc, 256 * TICKS_PER_S));
         last_speed_err = se;
         window_base = clamp32(avg);
         tick_no = 0;
      end
      e = clamp32(tilt - (tilt_setpoint_hold + TILT_OFFSET));
      tilt_acc = clamp32(tilt_acc + gain[REG_TILT_KI] * e);
      tilt_out = floor_div(gain[REG_TILT_KP] * e, 256) + floor_div(gain[REG_TILT_KD] * rate, 256)
               + floor_div(tilt_acc, 256 * TICKS_PER_S);
      e = clamp32(longint'(r.turn_target) - (rc - lc));
      turn = floor_div(gain[REG_TURN_KP] * e, 256)
           + floor_div(gain[REG_TURN_KD] * (e - last_turn_err) * TICKS_PER_S, 256);
      last_turn_err = e;
      sum_out  = duty_limit(tilt_out + turn);
      tilt_out = duty_limit(tilt_out);
      x = '0;
      x.drive_enabled = (tilt <= TILT_LIMIT && tilt >= -TILT_LIMIT);
      if (x.drive_enabled) begin
         held_dirs = {sum_out >= 0, tilt_out < 0};
         x.tilt_drive = 9'(tilt_out < 0 ? -tilt_out : tilt_out);
         x.sum_drive  = 9'(sum_out < 0 ? -sum_out : sum_out);
      end
      x.tilt_dir = held_dirs[0];
      x.sum_dir  = held_dirs[1];
      return x;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
      end
   endtask

   // handshake sampling, prediction and checking
   always @(posedge clock) begin
      rsp_type want;
      req_hs = !reset && req_valid && !req_stall;
      rsp_hs = !reset && rsp_valid && !rsp_stall;
      if (req_hs) expected_drives.push_back(predict_drive(req_payload));
      if (rsp_hs) begin
         if (expected_drives.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("%0t: result beat with none expected", $realtime);
         end else begin
            want = expected_drives.pop_front();
            check_field("tilt_drive", want.tilt_drive, rsp_payload.tilt_drive);
            check_field("sum_drive", want.sum_drive, rsp_payload.sum_drive);
            check_field("tilt_dir", want.tilt_dir, rsp_payload.tilt_dir);
            check_field("sum_dir", want.sum_dir, rsp_payload.sum_dir);
            check_field("drive_enabled", want.drive_enabled, rsp_payload.drive_enabled);
         end
      end
      quiet_cycles = (req_hs || rsp_hs) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // sender
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_hs) begin
         // stalled beat is held
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (pending_ticks.size() > 0) begin
         req_payload <= pending_ticks.pop_front();
         req_valid <= 1'b1;
         req_gap = idle_on ? $urandom_range(0, 6) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver, with one long hold-off on request
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(negedge clock) begin
      if (hold_ask && !hold_done) begin
         hold_left = 400;
         hold_done = 1'b1;
      end
      if (rsp_hs) stall_left = idle_on ? $urandom_range(0, 6) : 0;
      rsp_stall <= (stall_left > 0) || (hold_left > 0);
      if (stall_left > 0) stall_left--;
      if (hold_left > 0) hold_left--;
   end

   task automatic csr_write(reg_index_type idx, shortint value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      gain[idx] = value;
   endtask

   task automatic set_all_gains(int mode);
      reg_index_type idx;
      shortint       v;
      for (int i = 0; i < 8; i++) begin
         idx = reg_index_type'(i);
         case (mode)
            0: v = 16'sh7FFF;
            1: v = -16'sh8000;
            2: v = shortint'($urandom);
            default: v = shortint'($urandom_range(0, 1600)) - 16'sd800;
         endcase
         csr_write(idx, v);
      end
   endtask

   task automatic add_tick(int tilt, int rate, int rc, int lc, int st, int tt);
      req_type r;
      r.tilt_angle   = 16'(tilt);
      r.pitch_rate   = 16'(rate);
      r.right_count  = rc;
      r.left_count   = lc;
      r.speed_target = 16'(st);
      r.turn_target  = 16'(tt);
      pending_ticks.push_back(r);
   endtask

   // mostly plausible motion with slowly moving encoder totals, some pure noise
   task automatic add_motion(int n);
      int rc, lc;
      rc = $urandom;
      lc = $urandom;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 8) begin
            rc += $urandom_range(0, 80) - 40;
            lc += $urandom_range(0, 80) - 40;
            add_tick($urandom_range(0, 1800) - 900, $urandom_range(0, 8000) - 4000, rc, lc,
                     $urandom_range(0, 2000) - 1000, $urandom_range(0, 400) - 200);
         end else begin
            add_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic drain;
      while (pending_ticks.size() > 0 || req_valid || expected_drives.size() > 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero gains: drives zero, sum direction set
      add_tick(0, 0, 0, 0, 0, 0);
      add_tick(640, 0, 0, 0, 0, 0);
      add_tick(641, 0, 0, 0, 0, 0);
      drain();
      set_all_gains(0);
      add_tick(640, 32767, 32'h7FFFFFFF, 32'h7FFFFFFF, 32767, 32767);
      add_tick(-640, -32768, 32'h80000000, 32'h80000000, -32768, -32768);
      add_tick(641, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0);
      add_tick(-641, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0);
      add_tick(32767, 32767, 0, 0, 32767, 0);
      add_tick(-32768, -32768, 0, 0, -32768, 0);
      add_tick(0, 0, -1, 0, 0, -1);
      add_tick(16, -16, 1, -1, 5, 2);
      drain();
      set_all_gains(1);
      add_tick(0, 0, 0, 0, 0, 0);
      add_tick(640, -32768, 32'h7FFFFFFF, 32'h80000000, 32767, -32768);
      add_tick(-641, 32767, 32'h80000000, 32'h7FFFFFFF, -32768, 32767);
      add_tick(-640, 100, 12, 11, 0, 0);
      add_motion(30);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         set_all_gains(ph == 1 ? 2 : 3);
         idle_on = (ph != 2);
         if (ph == 3) begin
            idle_on = 1'b0;
            hold_ask = 1'b1;
         end
         add_motion(85);
         drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_drives.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
